// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tmsgd_pkg.sv -----
`default_nettype none

package tmsgd_pkg;

    localparam int FRAC        = 16;
    localparam int W_W         = 24;
    localparam int EST_W       = FRAC + 1;
    localparam int LOSS_W      = 16;
    localparam int ETA_W       = 23;
    localparam int IDX_BITS    = 4;
    localparam int NUM_WEIGHTS = 9;
    localparam int MUL_W       = 28;
    localparam int Q_W         = 2 * MUL_W - FRAC;
    localparam int ACC_W       = 36;

    localparam logic [EST_W-1:0] ONE  = EST_W'(1) << FRAC;
    localparam logic [EST_W-1:0] HALF = EST_W'(1) << (FRAC - 1);
    localparam logic [ETA_W-1:0] ETA_RESET = ETA_W'(32768);

    typedef enum logic [1:0] {
        OP_TRAIN = 2'd0,
        OP_INFER = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Weight indices
    localparam logic [IDX_BITS-1:0] WI_W11 = 4'd0;
    localparam logic [IDX_BITS-1:0] WI_W12 = 4'd1;
    localparam logic [IDX_BITS-1:0] WI_C1  = 4'd2;
    localparam logic [IDX_BITS-1:0] WI_W21 = 4'd3;
    localparam logic [IDX_BITS-1:0] WI_W22 = 4'd4;
    localparam logic [IDX_BITS-1:0] WI_C2  = 4'd5;
    localparam logic [IDX_BITS-1:0] WI_V1  = 4'd6;
    localparam logic [IDX_BITS-1:0] WI_V2  = 4'd7;
    localparam logic [IDX_BITS-1:0] WI_C3  = 4'd8;

    typedef enum logic [5:0] {
        ST_H1A, ST_H1B, ST_H1C,
        ST_H2A, ST_H2B, ST_H2C,
        ST_YA, ST_YB, ST_YC, ST_YSIG,
        ST_ERR, ST_LOSS,
        ST_D3, ST_H1D, ST_D1A, ST_D1B, ST_H2D, ST_D2A, ST_D2B,
        ST_G0, ST_U0, ST_G1, ST_U1, ST_U2,
        ST_G3, ST_U3, ST_G4, ST_U4, ST_U5,
        ST_G6, ST_U6, ST_G7, ST_U7, ST_U8
    } step_t;

    typedef struct packed {
        op_t                    op;
        logic signed [W_W-1:0]  x_first;
        logic signed [W_W-1:0]  x_second;
        logic [EST_W-1:0]       target;
        logic [IDX_BITS-1:0]    weight_index;
        logic signed [W_W-1:0]  weight_data;
    } in_item_t;

    typedef struct packed {
        logic [EST_W-1:0]       estimate;
        logic                   decision;
        logic [LOSS_W-1:0]      sample_loss;
        logic signed [W_W-1:0]  weight_read;
    } out_item_t;

    typedef struct packed {
        logic  accept;
        logic  run;
        step_t step;
        logic  publish;
    } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/tmsgd_seq.sv -----
`default_nettype none

module tmsgd_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire tmsgd_pkg::op_t in_op,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output tmsgd_pkg::ctrl_t    ctrl
);
    import tmsgd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   train_reg, train_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept, publish, last_step;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign publish   = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign last_step = train_reg ? (step_reg == ST_U8) : (step_reg == ST_LOSS);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctrl.accept  = accept;
        ctrl.run     = (state_reg == S_CALC);
        ctrl.step    = step_reg;
        ctrl.publish = publish;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        train_next = train_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_TRAIN || in_op == OP_INFER)
                    begin
                        state_next = S_CALC;
                        step_next  = ST_H1A;
                        train_next = (in_op == OP_TRAIN);
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_CALC:
            begin
                if (last_step)
                    state_next = S_FINISH;
                else
                    step_next = step_t'(step_reg + 6'd1);
            end
            S_FINISH:
            begin
                if (publish)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // hold the result until the downstream transfer completes
        if (publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_H1A;
            train_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            train_reg     <= train_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tmsgd_dp.sv -----
`default_nettype none

module tmsgd_dp #(
    parameter int SIG_DEPTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tmsgd_pkg::in_item_t          in_data,
    input  wire tmsgd_pkg::ctrl_t             ctrl,
    input  wire logic                         cfg_write,
    input  wire logic [tmsgd_pkg::ETA_W-1:0]  cfg_data,
    output tmsgd_pkg::out_item_t              out_data
);
    import tmsgd_pkg::*;

    localparam int TIDX_W = $clog2(SIG_DEPTH);
    localparam int ZW     = FRAC + 4;
    localparam int UP_W   = ZW + TIDX_W + 1;
    localparam logic signed [ACC_W-1:0] Z_LO = -(ACC_W'(8) << FRAC);
    localparam logic signed [ACC_W-1:0] Z_HI = (ACC_W'(8) << FRAC) - ACC_W'(1);
    localparam logic signed [Q_W-1:0] W_MAX = Q_W'(8388607);
    localparam logic signed [Q_W-1:0] W_MIN = -Q_W'(8388608);

    typedef logic [EST_W-1:0] sig_tab_t [SIG_DEPTH];

    function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [EST_W-1:0] sig_entry(input int i);
        logic [63:0] one, t, m, q1, r1, f, g, pos, neg, term, num, den, quo, rem;
        logic        positive;
        int          n, k;
        one = 64'd1 << 60;
        t   = 64'(2 * i + 1);
        positive = t > 64'(SIG_DEPTH);
        m   = positive ? t - 64'(SIG_DEPTH) : 64'(SIG_DEPTH) - t;
        q1  = (m << 30) / 64'(SIG_DEPTH);
        r1  = (m << 30) % 64'(SIG_DEPTH);
        f   = (q1 << 30) + ((r1 << 30) / 64'(SIG_DEPTH));
        pos  = one;
        neg  = 64'd0;
        term = one;
        for (n = 1; n < 48; n++)
        begin
            term = mul60(term, f) / 64'(n);
            if (term == 64'd0)
                break;
            if ((n & 1) != 0)
                neg = neg + term;
            else
                pos = pos + term;
        end
        g = pos - neg;
        g = mul60(g, g);
        g = mul60(g, g);
        g = mul60(g, g);
        num = positive ? one : g;
        den = one + g;
        rem = num;
        quo = 64'd0;
        if (rem >= den)
        begin
            quo = 64'd1;
            rem = rem - den;
        end
        for (k = 0; k < FRAC + 1; k++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        quo = (quo + 64'd1) >> 1;
        return quo[EST_W-1:0];
    endfunction

    function automatic sig_tab_t build_tab();
        sig_tab_t tab;
        for (int i = 0; i < SIG_DEPTH; i++)
            tab[i] = sig_entry(i);
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_tab();

    logic signed [W_W-1:0]   w_reg [NUM_WEIGHTS];
    logic [ETA_W-1:0]        eta_reg;
    op_t                     op_reg;
    logic signed [W_W-1:0]   x1_reg, x2_reg, rd_reg;
    logic [EST_W-1:0]        y_reg, h1_reg, h2_reg, yh_reg;
    logic signed [MUL_W-1:0] e_reg, tmp_reg, d1_reg, d2_reg, d3_reg, g_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [LOSS_W-1:0]       loss_reg;

    logic [IDX_BITS-1:0]       wsel;
    logic signed [W_W-1:0]     wval;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic signed [Q_W-1:0]     q, upd;
    logic signed [W_W-1:0]     w_new;
    logic signed [ACC_W-1:0]   zc;
    logic [ZW-1:0]             zu;
    logic [UP_W-1:0]           zprod;
    logic [EST_W-1:0]          sig_val;
    logic                      w_write, idx_ok;

    assign idx_ok = (in_data.weight_index < IDX_BITS'(NUM_WEIGHTS));

    function automatic logic signed [MUL_W-1:0] ext_u(input logic [EST_W-1:0] v);
        return MUL_W'(v);
    endfunction

    function automatic logic signed [MUL_W-1:0] ext_s(input logic signed [W_W-1:0] v);
        return {{(MUL_W-W_W){v[W_W-1]}}, v};
    endfunction

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        wsel    = ctrl.accept ? in_data.weight_index : WI_W11;
        w_write = 1'b0;
        if (ctrl.run)
        begin
            unique case (ctrl.step)
                ST_H1A: begin wsel = WI_W11; mul_b = ext_s(x1_reg); end
                ST_H1B: begin wsel = WI_W12; mul_b = ext_s(x2_reg); end
                ST_H1C: begin wsel = WI_C1;  mul_b = ext_u(ONE); end
                ST_H2A: begin wsel = WI_W21; mul_b = ext_s(x1_reg); end
                ST_H2B: begin wsel = WI_W22; mul_b = ext_s(x2_reg); end
                ST_H2C: begin wsel = WI_C2;  mul_b = ext_u(ONE); end
                ST_YA:  begin wsel = WI_V1;  mul_b = ext_u(h1_reg); end
                ST_YB:  begin wsel = WI_V2;  mul_b = ext_u(h2_reg); end
                ST_YC:  begin wsel = WI_C3;  mul_b = ext_u(ONE); end
                ST_YSIG: ;
                ST_ERR:  begin mul_a = ext_u(yh_reg); mul_b = ext_u(ONE - yh_reg); end
                ST_LOSS: begin mul_a = e_reg; mul_b = e_reg; end
                ST_D3:   begin mul_a = e_reg; mul_b = tmp_reg; end
                ST_H1D:  begin mul_a = ext_u(h1_reg); mul_b = ext_u(ONE - h1_reg); end
                ST_D1A:  begin wsel = WI_V1; mul_a = d3_reg; end
                ST_D1B:  begin mul_a = d1_reg; mul_b = tmp_reg; end
                ST_H2D:  begin mul_a = ext_u(h2_reg); mul_b = ext_u(ONE - h2_reg); end
                ST_D2A:  begin wsel = WI_V2; mul_a = d3_reg; end
                ST_D2B:  begin mul_a = d2_reg; mul_b = tmp_reg; end
                ST_G0:   begin mul_a = d1_reg; mul_b = ext_s(x1_reg); end
                ST_G1:   begin mul_a = d1_reg; mul_b = ext_s(x2_reg); end
                ST_G3:   begin mul_a = d2_reg; mul_b = ext_s(x1_reg); end
                ST_G4:   begin mul_a = d2_reg; mul_b = ext_s(x2_reg); end
                ST_G6:   begin mul_a = d3_reg; mul_b = ext_u(h1_reg); end
                ST_G7:   begin mul_a = d3_reg; mul_b = ext_u(h2_reg); end
                ST_U0:   begin wsel = WI_W11; mul_b = g_reg;  w_write = 1'b1; end
                ST_U1:   begin wsel = WI_W12; mul_b = g_reg;  w_write = 1'b1; end
                ST_U2:   begin wsel = WI_C1;  mul_b = d1_reg; w_write = 1'b1; end
                ST_U3:   begin wsel = WI_W21; mul_b = g_reg;  w_write = 1'b1; end
                ST_U4:   begin wsel = WI_W22; mul_b = g_reg;  w_write = 1'b1; end
                ST_U5:   begin wsel = WI_C2;  mul_b = d2_reg; w_write = 1'b1; end
                ST_U6:   begin wsel = WI_V1;  mul_b = g_reg;  w_write = 1'b1; end
                ST_U7:   begin wsel = WI_V2;  mul_b = g_reg;  w_write = 1'b1; end
                ST_U8:   begin wsel = WI_C3;  mul_b = d3_reg; w_write = 1'b1; end
                default: ;
            endcase
            // weight operand for forward sums and hidden-delta products; eta for the updates
            case (ctrl.step) inside
                ST_H1A, ST_H1B, ST_H1C, ST_H2A, ST_H2B, ST_H2C, ST_YA, ST_YB, ST_YC:
                    mul_a = ext_s(wval);
                ST_D1A, ST_D2A:
                    mul_b = ext_s(wval);
                ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_U8:
                    mul_a = MUL_W'(eta_reg);
                default: ;
            endcase
        end
    end

    assign wval = (wsel < IDX_BITS'(NUM_WEIGHTS)) ? w_reg[wsel] : '0;
    assign prod = mul_a * mul_b;
    assign q    = prod[2*MUL_W-1:FRAC];

    // gradient step, saturated to the weight width
    always_comb
    begin
        upd = {{(Q_W-W_W){wval[W_W-1]}}, wval} - q;
        if (upd > W_MAX)
            w_new = W_MAX[W_W-1:0];
        else if (upd < W_MIN)
            w_new = W_MIN[W_W-1:0];
        else
            w_new = upd[W_W-1:0];
    end

    // clamp into [-8,8) and scale into the table
    always_comb
    begin
        if (acc_reg < Z_LO)
            zc = Z_LO;
        else if (acc_reg > Z_HI)
            zc = Z_HI;
        else
            zc = acc_reg;
        zu      = ZW'(zc - Z_LO);
        zprod   = UP_W'(zu) * UP_W'(SIG_DEPTH);
        sig_val = SIG_TAB[zprod[ZW +: TIDX_W]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_WEIGHTS; k++)
                w_reg[k] <= '0;
            eta_reg <= ETA_RESET;
            op_reg  <= OP_TRAIN;
        end
        else
        begin
            if (cfg_write)
                eta_reg <= cfg_data;
            if (ctrl.accept)
            begin
                op_reg <= in_data.op;
                if (in_data.op == OP_WRITE && idx_ok)
                    w_reg[in_data.weight_index] <= in_data.weight_data;
            end
            else if (w_write)
            begin
                w_reg[wsel] <= w_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            x1_reg <= in_data.x_first;
            x2_reg <= in_data.x_second;
            y_reg  <= (in_data.target > ONE) ? ONE : in_data.target;
            rd_reg <= idx_ok ? wval : '0;
        end
        if (ctrl.run)
        begin
            case (ctrl.step) inside
                ST_H1A, ST_H2A, ST_YA:
                    acc_reg <= q[ACC_W-1:0];
                ST_H1B, ST_H1C, ST_H2B, ST_H2C, ST_YB, ST_YC:
                    acc_reg <= acc_reg + q[ACC_W-1:0];
                default: ;
            endcase
            case (ctrl.step) inside
                ST_H2A:  h1_reg <= sig_val;
                ST_YA:   h2_reg <= sig_val;
                ST_YSIG: yh_reg <= sig_val;
                ST_ERR:
                begin
                    e_reg   <= ext_u(yh_reg) - ext_u(y_reg);
                    tmp_reg <= q[MUL_W-1:0];
                end
                ST_LOSS: loss_reg <= q[LOSS_W:1];
                ST_D3:   d3_reg <= q[MUL_W-1:0];
                ST_H1D, ST_H2D: tmp_reg <= q[MUL_W-1:0];
                ST_D1A, ST_D1B: d1_reg <= q[MUL_W-1:0];
                ST_D2A, ST_D2B: d2_reg <= q[MUL_W-1:0];
                ST_G0, ST_G1, ST_G3, ST_G4, ST_G6, ST_G7: g_reg <= q[MUL_W-1:0];
                default: ;
            endcase
        end
        if (ctrl.publish)
        begin
            if (op_reg == OP_WRITE || op_reg == OP_READ)
            begin
                out_data.estimate    <= '0;
                out_data.decision    <= 1'b0;
                out_data.sample_loss <= '0;
                out_data.weight_read <= (op_reg == OP_READ) ? rd_reg : '0;
            end
            else
            begin
                out_data.estimate    <= yh_reg;
                out_data.decision    <= (yh_reg >= HALF);
                out_data.sample_loss <= loss_reg;
                out_data.weight_read <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tiny_mlp_sgd_trainer.sv -----
// Channel | Direction | Payload     | Transfer when
// in      | input     | in_item_t   | in_valid && in_ready
// out     | output    | out_item_t  | out_valid && out_ready
// cfg     | input     | eta, 23 bit | cfg_valid && cfg_ready (always ready)
//
// One item is in flight at a time, and every compute step shares the single 28x28
// multiplier.
// The next item is taken while a finished result waits on out_ready.
// Reset clears the nine weights and sets eta to one half.
`default_nettype none
`include "assert_macros.svh"

module tiny_mlp_sgd_trainer #(
    parameter int SIGMOID_TABLE_DEPTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire tmsgd_pkg::in_item_t          in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output tmsgd_pkg::out_item_t              out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tmsgd_pkg::ETA_W-1:0]  cfg_data
);
    import tmsgd_pkg::*;

    ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    tmsgd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_data.op),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    tmsgd_dp #(
        .SIG_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctrl      (ctrl),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

    `ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready right after transfer")
    `ASSERT_IMPLY(a_no_run_idle, ctrl.run, !in_ready, "sequencer running while ready")
    `ASSERT_IMPLY(a_decision, out_valid,
                  out_data.decision == (out_data.estimate >= HALF), "decision mismatch")
    `ASSERT_IMPLY(a_ranges, out_valid,
                  out_data.estimate <= ONE && out_data.sample_loss <= 16'd32768,
                  "result out of range")

endmodule

`default_nettype wire
